// ===== design/bpa_pkg.sv =====
// Shared types, sizes and helpers for the bitmap page allocator.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package bpa_pkg;

  localparam int PAGES     = 4096;
  localparam int INDEX_W   = 16;
  localparam int GRANT_W   = 12;
  localparam int REQ_W     = 2;
  localparam int WORD_W    = (PAGES >= 64) ? 32 : 4;
  localparam int NUM_WORDS = (PAGES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int CNT_W     = $clog2(PAGES + 1);
  localparam int LAST_BITS = PAGES - (NUM_WORDS - 1) * WORD_W;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WADDR_W-1:0] waddr_t;
  typedef logic [BIT_W-1:0]   bitpos_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } mem_wr_t;

  // Reset image of one word: bits past the last page read as used so the scan skips them.
  function automatic word_t pad_word(waddr_t addr);
    word_t w;
    w = '0;
    if (addr == WADDR_W'(NUM_WORDS - 1)) begin
      for (int i = 0; i < WORD_W; i++) begin
        w[i] = (i >= LAST_BITS);
      end
    end
    return w;
  endfunction

  function automatic waddr_t next_addr(waddr_t addr);
    waddr_t n;
    n = (addr == WADDR_W'(NUM_WORDS - 1)) ? '0 : addr + 1'b1;
    return n;
  endfunction

  function automatic logic [GRANT_W-1:0] grant_of(waddr_t w, bitpos_t b);
    logic [WADDR_W+BIT_W-1:0] full;
    full = {w, b};
    return GRANT_W'(full);
  endfunction

endpackage

`default_nettype wire

// ===== design/bpa_map_mem.sv =====
// Bitmap store: one word of page-used bits per entry, one write and one read port.
// Read data is registered. Uses bpa_pkg types.
`default_nettype none

module bpa_map_mem (
  input  wire logic             clk,
  input  wire bpa_pkg::mem_wr_t wr,
  input  wire bpa_pkg::waddr_t  raddr,
  output bpa_pkg::word_t        rdata
);

  bpa_pkg::word_t mem [bpa_pkg::NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bpa_scan.sv =====
// Find-first-free search over one bitmap word, starting at a given bit.
// Pure logic; uses bpa_pkg widths.
`default_nettype none

module bpa_scan (
  input  wire bpa_pkg::word_t   word,
  input  wire bpa_pkg::bitpos_t start,
  output logic                  found,
  output bpa_pkg::bitpos_t      pos
);

  always_comb begin
    found = 1'b0;
    pos   = '0;
    // walk down so the lowest qualifying bit wins
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i] && (i >= int'(start))) begin
        found = 1'b1;
        pos   = bpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bitmap_page_allocator_top.sv =====
// Top level of the bitmap page allocator: control sequencer, pointer and count registers.
// Depends on bpa_pkg, bpa_map_mem and bpa_scan.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   request  | in_valid/in_ready  | req_type[1:0], page_index[15:0]
//   result   | out_valid/out_ready| success, granted_page[11:0], page_free
//
// After reset a clearing pass writes every bitmap word in turn, with in_ready low.
// A request then runs through accept with the word read, modify/write-back and
// result hand-off. An allocate whose next free page lies beyond the current word
// adds a scan that reads the following bitmap words one at a time (one read port).
// A result waiting on out_ready stalls only the hand-off; the next request is taken
// as soon as the previous result sits in the output register.
`default_nettype none

module bitmap_page_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] page_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             success,
  output logic [11:0]      granted_page,
  output logic             page_free
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state;
  bpa_pkg::waddr_t       clr_addr;
  bpa_pkg::req_t         req;
  bpa_pkg::waddr_t       pg_word;
  bpa_pkg::bitpos_t      pg_bit;
  logic                  in_range;
  bpa_pkg::waddr_t       nf_word;
  bpa_pkg::bitpos_t      nf_bit;
  bpa_pkg::count_t       used_count;
  bpa_pkg::waddr_t       scan_addr;
  bpa_pkg::waddr_t       chk_addr;
  logic                  chk_valid;
  logic                  res_success;
  logic [11:0]           res_grant;
  logic                  res_free;

  bpa_pkg::mem_wr_t      mem_wr;
  bpa_pkg::waddr_t       raddr;
  bpa_pkg::word_t        rdata;
  bpa_pkg::word_t        scan_word;
  bpa_pkg::bitpos_t      scan_start;
  logic                  scan_found;
  bpa_pkg::bitpos_t      scan_pos;
  bpa_pkg::bitpos_t      cur_bit;
  logic                  bit_set;
  logic                  is_full;
  logic                  fills_last;
  logic                  in_accept;
  logic                  out_slot;
  bpa_pkg::word_t        alloc_word;

  assign in_ready   = (state == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign out_slot   = !out_valid || out_ready;
  assign cur_bit    = (req == bpa_pkg::REQ_ALLOC) ? nf_bit : pg_bit;
  assign bit_set    = rdata[cur_bit];
  assign is_full    = (used_count == bpa_pkg::CNT_W'(bpa_pkg::PAGES));
  assign fills_last = (used_count == bpa_pkg::CNT_W'(bpa_pkg::PAGES - 1));
  assign alloc_word = rdata | (bpa_pkg::word_t'(1) << nf_bit);

  // Read address: the next-free word (allocate) or the request's word on accept, the scan pointer while scanning.
  always_comb begin
    case (state)
      ST_IDLE: begin
        if (bpa_pkg::req_t'(req_type) == bpa_pkg::REQ_ALLOC) begin
          raddr = nf_word;
        end else begin
          raddr = page_index[bpa_pkg::BIT_W +: bpa_pkg::WADDR_W];
        end
      end
      ST_SCAN: raddr = scan_addr;
      default: raddr = pg_word;
    endcase
  end

  always_comb begin
    mem_wr = '0;
    case (state)
      ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_addr;
        mem_wr.data = bpa_pkg::pad_word(clr_addr);
      end
      ST_EXEC: begin
        if (req == bpa_pkg::REQ_ALLOC && !is_full) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = nf_word;
          mem_wr.data = alloc_word;
        end else if (req == bpa_pkg::REQ_FREE && in_range && bit_set) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = pg_word;
          mem_wr.data = rdata & ~(bpa_pkg::word_t'(1) << pg_bit);
        end
      end
      default: mem_wr = '0;
    endcase
  end

  // First look uses the freshly marked word (forwarded), later words come from memory.
  always_comb begin
    if (state == ST_EXEC) begin
      scan_word  = alloc_word;
      scan_start = nf_bit;
    end else begin
      scan_word  = rdata;
      scan_start = '0;
    end
  end

  bpa_map_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  bpa_scan u_scan (
    .word  (scan_word),
    .start (scan_start),
    .found (scan_found),
    .pos   (scan_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      nf_word    <= '0;
      nf_bit     <= '0;
      used_count <= '0;
      chk_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= bpa_pkg::next_addr(clr_addr);
          if (clr_addr == bpa_pkg::WADDR_W'(bpa_pkg::NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            req      <= bpa_pkg::req_t'(req_type);
            in_range <= {1'b0, page_index} < (bpa_pkg::INDEX_W + 1)'(bpa_pkg::PAGES);
            pg_bit   <= page_index[bpa_pkg::BIT_W-1:0];
            pg_word  <= page_index[bpa_pkg::BIT_W +: bpa_pkg::WADDR_W];
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (req)
            bpa_pkg::REQ_ALLOC: begin
              res_free <= 1'b0;
              if (!is_full) begin
                res_success <= 1'b1;
                res_grant   <= bpa_pkg::grant_of(nf_word, nf_bit);
                used_count  <= used_count + 1'b1;
                // when the last page goes, the pointer stays on it
                if (!fills_last && !scan_found) begin
                  scan_addr <= bpa_pkg::next_addr(nf_word);
                  chk_valid <= 1'b0;
                  state     <= ST_SCAN;
                end else begin
                  if (!fills_last) begin
                    nf_bit <= scan_pos;
                  end
                  state <= ST_DONE;
                end
              end else begin
                res_success <= 1'b0;
                res_grant   <= '0;
                state       <= ST_DONE;
              end
            end
            bpa_pkg::REQ_FREE: begin
              res_success <= in_range && bit_set;
              res_grant   <= '0;
              res_free    <= 1'b0;
              state       <= ST_DONE;
              if (in_range && bit_set) begin
                nf_word     <= pg_word;
                nf_bit      <= pg_bit;
                used_count  <= used_count - 1'b1;
              end
            end
            bpa_pkg::REQ_QUERY: begin
              res_success <= 1'b0;
              res_grant   <= '0;
              res_free    <= in_range && !bit_set;
              state       <= ST_DONE;
            end
            default: begin
              res_success <= 1'b0;
              res_grant   <= '0;
              res_free    <= 1'b0;
              state       <= ST_DONE;
            end
          endcase
        end
        ST_SCAN: begin
          // issue one read per cycle; check the word read in the previous cycle
          scan_addr <= bpa_pkg::next_addr(scan_addr);
          chk_addr  <= scan_addr;
          chk_valid <= 1'b1;
          if (chk_valid && scan_found) begin
            nf_word <= chk_addr;
            nf_bit  <= scan_pos;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_slot) begin
            out_valid    <= 1'b1;
            success      <= res_success;
            granted_page <= res_grant;
            page_free    <= res_free;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= bpa_pkg::CNT_W'(bpa_pkg::PAGES))
    else $error("allocated count exceeds page total");

  a_scan_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (used_count < bpa_pkg::CNT_W'(bpa_pkg::PAGES)))
    else $error("scan running with no free page");

  a_grant_needs_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (granted_page != '0)) |-> success)
    else $error("granted page reported without success");

  a_free_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(success && page_free))
    else $error("success and page_free both set");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && req == bpa_pkg::REQ_QUERY) |=> $stable(used_count))
    else $error("query changed the allocated count");

endmodule

`default_nettype wire

// ===== dv/tb_bitmap_page_allocator_top.sv =====
// Self-checking testbench for bitmap_page_allocator_top: directed corner requests, then
// random allocate/free/query and no-op traffic under bursty valid/ready.
// Depends on bpa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb_bitmap_page_allocator_top;

  typedef struct {
    logic                        success;
    logic [bpa_pkg::GRANT_W-1:0] granted_page;
    logic                        page_free;
  } reply_t;

  // Mirror of the allocator: bitmap, next-free cursor, page count and pending replies.
  class page_ledger;
    bit     used_pages[bpa_pkg::PAGES];
    int     cursor;
    int     taken;
    int     errors;
    reply_t pending_replies[$];

    function void record_request(bpa_pkg::req_t kind, logic [bpa_pkg::INDEX_W-1:0] idx);
      reply_t r;
      int     p;
      r = '{1'b0, '0, 1'b0};
      case (kind)
        bpa_pkg::REQ_ALLOC: begin
          if (taken < bpa_pkg::PAGES) begin
            p = cursor;
            used_pages[p] = 1'b1;
            r.success = 1'b1;
            r.granted_page = bpa_pkg::GRANT_W'(p);
            taken++;
            // park on the granted page once the map is full
            if (taken < bpa_pkg::PAGES) begin
              while (used_pages[p]) p = (p + 1) % bpa_pkg::PAGES;
            end
            cursor = p;
          end
        end
        bpa_pkg::REQ_FREE: begin
          if (idx < bpa_pkg::PAGES && used_pages[idx]) begin
            used_pages[idx] = 1'b0;
            cursor = idx;
            taken--;
            r.success = 1'b1;
          end
        end
        bpa_pkg::REQ_QUERY: r.page_free = (idx < bpa_pkg::PAGES) && !used_pages[idx];
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic s, logic [bpa_pkg::GRANT_W-1:0] g, logic f);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, actual success=%0b granted_page=%0d page_free=%0b",
                 $time, s, g, f);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (s !== e.success) begin
        $display("%0t: success mismatch, expected %0b, actual %0b", $time, e.success, s);
        errors++;
      end
      if (g !== e.granted_page) begin
        $display("%0t: granted_page mismatch, expected %0d, actual %0d",
                 $time, e.granted_page, g);
        errors++;
      end
      if (f !== e.page_free) begin
        $display("%0t: page_free mismatch, expected %0b, actual %0b", $time, e.page_free, f);
        errors++;
      end
    endfunction

    function int pick_used_page();
      int p;
      p = 0;
      for (int i = 0; i < 16; i++) begin
        p = $urandom_range(0, bpa_pkg::PAGES - 1);
        if (used_pages[p]) return p;
      end
      return p;
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   req_type;
  logic [bpa_pkg::INDEX_W-1:0]  page_index;
  logic                         out_valid;
  logic                         out_ready;
  logic                         success;
  logic [bpa_pkg::GRANT_W-1:0]  granted_page;
  logic                         page_free;

  page_ledger ledger = new();
  int         burst_left = 0;

  bitmap_page_allocator_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .page_index   (page_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .success      (success),
    .granted_page (granted_page),
    .page_free    (page_free)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Send one request; called at a falling edge, returns at the falling edge after acceptance.
  task automatic issue(bpa_pkg::req_t kind, logic [bpa_pkg::INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    req_type   <= kind;
    page_index <= idx;
    do @(posedge clk); while (!in_ready);
    ledger.record_request(kind, idx);
    @(negedge clk);
  endtask

  // Hold off until every reply is back, then let a worst-case scan run out.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (ledger.pending_replies.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      int mode;
      int len;
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) ledger.check_reply(success, granted_page, page_free);
  end

  initial begin
    int alloc_pct;
    int roll;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = bpa_pkg::REQ_ALLOC;
    page_index = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, starting from an empty map
    issue(bpa_pkg::REQ_QUERY, 16'd0);
    issue(bpa_pkg::REQ_QUERY, 16'(bpa_pkg::PAGES - 1));
    issue(bpa_pkg::REQ_QUERY, 16'(bpa_pkg::PAGES));
    issue(bpa_pkg::REQ_QUERY, 16'hFFFF);
    issue(bpa_pkg::REQ_FREE,  16'd7);
    issue(bpa_pkg::REQ_FREE,  16'hFFFF);
    issue(bpa_pkg::REQ_FREE,  16'(bpa_pkg::PAGES));
    issue(bpa_pkg::REQ_NONE,  16'hFFFF);
    issue(bpa_pkg::REQ_NONE,  16'd0);
    issue(bpa_pkg::REQ_ALLOC, 16'hFFFF);
    issue(bpa_pkg::REQ_ALLOC, 16'd0);
    issue(bpa_pkg::REQ_ALLOC, 16'd0);
    issue(bpa_pkg::REQ_QUERY, 16'd1);
    issue(bpa_pkg::REQ_FREE,  16'd1);
    issue(bpa_pkg::REQ_ALLOC, 16'd0);
    issue(bpa_pkg::REQ_FREE,  16'd0);
    issue(bpa_pkg::REQ_FREE,  16'd0);
    issue(bpa_pkg::REQ_QUERY, 16'd0);
    issue(bpa_pkg::REQ_ALLOC, 16'd0);
    issue(bpa_pkg::REQ_ALLOC, 16'd0);
    drain();

    alloc_pct = 45;
    for (int n = 0; n < 1650; n++) begin
      if (n % 150 == 0) begin
        roll = $urandom_range(0, 2);
        alloc_pct = (roll == 0) ? 15 : (roll == 1) ? 45 : 75;
      end
      if (n % 400 == 399) drain();
      if ($urandom_range(0, 99) < 4) begin
        issue(bpa_pkg::REQ_NONE, 16'($urandom_range(0, 65535)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          issue(bpa_pkg::REQ_ALLOC, 16'($urandom_range(0, 65535)));
        end else if (roll < alloc_pct + (100 - alloc_pct) * 2 / 3) begin
          if ($urandom_range(0, 4) != 0) begin
            issue(bpa_pkg::REQ_FREE, 16'(ledger.pick_used_page()));
          end else begin
            issue(bpa_pkg::REQ_FREE, 16'($urandom_range(0, 65535)));
          end
        end else begin
          if ($urandom_range(0, 9) < 7) begin
            issue(bpa_pkg::REQ_QUERY, 16'($urandom_range(0, bpa_pkg::PAGES - 1)));
          end else begin
            issue(bpa_pkg::REQ_QUERY, 16'($urandom_range(0, 65535)));
          end
        end
      end
    end
    drain();

    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
